/* src/sphash_pkg.sv */
// Shared types, codes and constants of the substring polynomial hash engine.
`default_nettype none

package sphash_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W      = 10;
    localparam int CHAR_W     = 7;
    localparam int H1_W       = 30;
    localparam int H2_W       = 27;

    // Barrett reduction widths: quotient estimate and residue before correction (< 3m)
    localparam int MU1_W  = H1_W + 1;
    localparam int MU2_W  = H2_W + 1;
    localparam int RED1_W = H1_W + 2;
    localparam int RED2_W = H2_W + 2;

    // modular multiplier pipeline depth
    localparam int MM_LAT = 4;

    localparam logic [H1_W-1:0]   MOD_FIRST     = 30'd1000000009;
    localparam logic [H2_W-1:0]   MOD_SECOND    = 27'd100000007;
    localparam logic [4:0]        HASH_BASE     = 5'd31;
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd96;

    // 31^-1: 26*m1 and 28*m2 are both -1 mod 31
    localparam logic [H1_W-1:0] INV_FIRST  =
        H1_W'((64'd1 + 64'd26 * 64'(MOD_FIRST)) / 64'd31);
    localparam logic [H2_W-1:0] INV_SECOND =
        H2_W'((64'd1 + 64'd28 * 64'(MOD_SECOND)) / 64'd31);

    // floor(2^(2n) / m)
    localparam logic [MU1_W-1:0] MU_FIRST  =
        MU1_W'((64'd1 << (2 * H1_W)) / 64'(MOD_FIRST));
    localparam logic [MU2_W-1:0] MU_SECOND =
        MU2_W'((64'd1 << (2 * H2_W)) / 64'(MOD_SECOND));

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_HASH    = 2'd2,
        CMD_COMPARE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [CHAR_W-1:0] character;
        logic [IDX_W-1:0]  start_a;
        logic [IDX_W-1:0]  end_a;
        logic [IDX_W-1:0]  start_b;
        logic [IDX_W-1:0]  end_b;
    } t_in_item;

    typedef struct packed {
        logic [H1_W-1:0] hash_first;
        logic [H2_W-1:0] hash_second;
        logic            equal;
        logic            error;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BASE   = 2'd1,
        OP_INV    = 2'd2,
        OP_DIFF   = 2'd3
    } t_mul_op;

    typedef enum logic [1:0] {
        RD_HI_A = 2'd0,
        RD_LO_A = 2'd1,
        RD_HI_B = 2'd2,
        RD_LO_B = 2'd3
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    wr_tables;
        logic    wr_prefix;
        logic    upd_pow;
        logic    upd_inv;
        t_rd_sel rd_sel;
        logic    cap_en;
        t_rd_sel cap_sel;
        logic    diff;
        t_mul_op mul_op;
        logic    out_result;
        logic    out_error;
    } t_ctl;

    typedef struct packed {
        t_cmd command;
        logic bad;
        logic full;
    } t_status;

endpackage

`default_nettype wire

/* src/sphash_modmul.sv */
// Two-lane pipelined modular multiplier (Barrett reduction), one lane per modulus.
`default_nettype none

module sphash_modmul import sphash_pkg::*; (
    input  logic            i_clk,
    input  logic [H1_W-1:0] i_a1,
    input  logic [H1_W-1:0] i_b1,
    input  logic [H2_W-1:0] i_a2,
    input  logic [H2_W-1:0] i_b2,
    output logic [H1_W-1:0] o_r1,
    output logic [H2_W-1:0] o_r2
);

    localparam logic [RED1_W-1:0] M1     = RED1_W'(MOD_FIRST);
    localparam logic [RED1_W-1:0] TWO_M1 = RED1_W'(MOD_FIRST) << 1;
    localparam logic [RED2_W-1:0] M2     = RED2_W'(MOD_SECOND);
    localparam logic [RED2_W-1:0] TWO_M2 = RED2_W'(MOD_SECOND) << 1;

    // lane 1
    logic [2*H1_W-1:0]  r_p1;
    logic [RED1_W-1:0]  r_pl1_d;
    logic [RED1_W-1:0]  r_pl1_dd;
    logic [2*MU1_W-1:0] r_t1;
    logic [RED1_W-1:0]  r_qm1;
    logic [H1_W-1:0]    r_r1;
    logic [MU1_W-1:0]   q1_1;
    logic [MU1_W-1:0]   q3_1;
    logic [RED1_W-1:0]  red1;
    logic [RED1_W-1:0]  n_r1;

    // lane 2
    logic [2*H2_W-1:0]  r_p2;
    logic [RED2_W-1:0]  r_pl2_d;
    logic [RED2_W-1:0]  r_pl2_dd;
    logic [2*MU2_W-1:0] r_t2;
    logic [RED2_W-1:0]  r_qm2;
    logic [H2_W-1:0]    r_r2;
    logic [MU2_W-1:0]   q1_2;
    logic [MU2_W-1:0]   q3_2;
    logic [RED2_W-1:0]  red2;
    logic [RED2_W-1:0]  n_r2;

    assign q1_1 = r_p1[2*H1_W-1:H1_W-1];
    assign q3_1 = r_t1[2*MU1_W-1:H1_W+1];
    assign q1_2 = r_p2[2*H2_W-1:H2_W-1];
    assign q3_2 = r_t2[2*MU2_W-1:H2_W+1];

    assign red1 = r_pl1_dd - r_qm1;
    assign red2 = r_pl2_dd - r_qm2;

    // residue is below 3m
    always_comb begin
        priority if (red1 >= TWO_M1) begin
            n_r1 = red1 - TWO_M1;
        end else if (red1 >= M1) begin
            n_r1 = red1 - M1;
        end else begin
            n_r1 = red1;
        end
        priority if (red2 >= TWO_M2) begin
            n_r2 = red2 - TWO_M2;
        end else if (red2 >= M2) begin
            n_r2 = red2 - M2;
        end else begin
            n_r2 = red2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1     <= (2*H1_W)'(i_a1) * (2*H1_W)'(i_b1);
        r_pl1_d  <= RED1_W'(r_p1);
        r_t1     <= (2*MU1_W)'(q1_1) * (2*MU1_W)'(MU_FIRST);
        r_pl1_dd <= r_pl1_d;
        r_qm1    <= RED1_W'((2*MU1_W)'(q3_1) * (2*MU1_W)'(MOD_FIRST));
        r_r1     <= H1_W'(n_r1);

        r_p2     <= (2*H2_W)'(i_a2) * (2*H2_W)'(i_b2);
        r_pl2_d  <= RED2_W'(r_p2);
        r_t2     <= (2*MU2_W)'(q1_2) * (2*MU2_W)'(MU_SECOND);
        r_pl2_dd <= r_pl2_d;
        r_qm2    <= RED2_W'((2*MU2_W)'(q3_2) * (2*MU2_W)'(MOD_SECOND));
        r_r2     <= H2_W'(n_r2);
    end

    assign o_r1 = r_r1;
    assign o_r2 = r_r2;

endmodule

`default_nettype wire

/* src/sphash_ctrl.sv */
// Controller state machine: sequences clear, append and query beats.
`default_nettype none

module sphash_ctrl import sphash_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_ctl    o_ctl,
    output logic    o_busy
);

    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] READ_LAST  = CNT_W'(4);
    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(MM_LAT);
    localparam logic [CNT_W-1:0] APP_PREFIX = CNT_W'(MM_LAT);
    localparam logic [CNT_W-1:0] APP_POW    = CNT_W'(MM_LAT + 1);
    localparam logic [CNT_W-1:0] APP_INV    = CNT_W'(MM_LAT + 2);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_READ   = 6'b000100,
        S_DIFF   = 6'b001000,
        S_MUL    = 6'b010000,
        S_APPEND = 6'b100000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_ctl         = '0;
        o_ctl.mul_op  = OP_DIFF;
        o_ctl.rd_sel  = t_rd_sel'(r_cnt[1:0]);
        o_ctl.cap_sel = t_rd_sel'(2'(r_cnt - 1'b1));
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cnt = '0;
                unique case (i_status.command)
                    CMD_CLEAR: begin
                        o_ctl.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                    CMD_APPEND: begin
                        n_state = i_status.full ? S_IDLE : S_APPEND;
                    end
                    CMD_HASH, CMD_COMPARE: begin
                        if (i_status.bad) begin
                            o_ctl.out_error = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            S_READ: begin
                // address at count n, capture at count n+1
                o_ctl.cap_en = (r_cnt != '0);
                if (r_cnt == READ_LAST) begin
                    n_state = S_DIFF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIFF: begin
                o_ctl.diff = 1'b1;
                n_cnt      = '0;
                n_state    = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    o_ctl.out_result = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_APPEND: begin
                // three products issued back to back, retired at APP_PREFIX, APP_POW and APP_INV
                priority if (r_cnt == CNT_W'(1)) begin
                    o_ctl.mul_op = OP_BASE;
                end else if (r_cnt == CNT_W'(2)) begin
                    o_ctl.mul_op = OP_INV;
                end else begin
                    o_ctl.mul_op = OP_WEIGHT;
                end
                o_ctl.wr_tables = (r_cnt == '0);
                o_ctl.wr_prefix = (r_cnt == APP_PREFIX);
                o_ctl.upd_pow   = (r_cnt == APP_POW);
                if (r_cnt == APP_INV) begin
                    o_ctl.upd_inv = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* src/sphash_dp.sv */
// Datapath: item register, prefix and power tables, running powers, result register.
`default_nettype none

module sphash_dp import sphash_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_ctl      i_ctl,
    output t_status   o_status,
    output t_out_item o_result,
    output logic      o_done
);

    function automatic logic [H1_W-1:0] sub_first(input logic [H1_W-1:0] a,
                                                  input logic [H1_W-1:0] b);
        return (a >= b) ? (a - b) : (a + MOD_FIRST - b);
    endfunction

    function automatic logic [H2_W-1:0] sub_second(input logic [H2_W-1:0] a,
                                                   input logic [H2_W-1:0] b);
        return (a >= b) ? (a - b) : (a + MOD_SECOND - b);
    endfunction

    function automatic logic [H1_W-1:0] add_first(input logic [H1_W-1:0] a,
                                                  input logic [H1_W-1:0] b);
        logic [H1_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, MOD_FIRST}) ? H1_W'(sum - {1'b0, MOD_FIRST}) : H1_W'(sum);
    endfunction

    function automatic logic [H2_W-1:0] add_second(input logic [H2_W-1:0] a,
                                                   input logic [H2_W-1:0] b);
        logic [H2_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, MOD_SECOND}) ? H2_W'(sum - {1'b0, MOD_SECOND}) : H2_W'(sum);
    endfunction

    t_in_item r_item;

    // string state
    logic [LEN_W-1:0] r_len;
    logic [H1_W-1:0]  r_pow1;
    logic [H2_W-1:0]  r_pow2;
    logic [H1_W-1:0]  r_inv1;
    logic [H2_W-1:0]  r_inv2;
    logic [H1_W-1:0]  r_last1;
    logic [H2_W-1:0]  r_last2;

    // tables
    logic [H1_W-1:0] r_mem_pre1 [MAX_LENGTH];
    logic [H2_W-1:0] r_mem_pre2 [MAX_LENGTH];
    logic [H1_W-1:0] r_mem_pow1 [MAX_LENGTH];
    logic [H2_W-1:0] r_mem_pow2 [MAX_LENGTH];
    logic [H1_W-1:0] r_mem_inv1 [MAX_LENGTH];
    logic [H2_W-1:0] r_mem_inv2 [MAX_LENGTH];
    logic [H1_W-1:0] r_pre1_rd;
    logic [H2_W-1:0] r_pre2_rd;
    logic [H1_W-1:0] r_pow1_rd;
    logic [H2_W-1:0] r_pow2_rd;
    logic [H1_W-1:0] r_inv1_rd;
    logic [H2_W-1:0] r_inv2_rd;

    // query operands
    logic [H1_W-1:0] r_hi_a1, r_lo_a1, r_hi_b1, r_lo_b1, r_da1, r_db1;
    logic [H2_W-1:0] r_hi_a2, r_lo_a2, r_hi_b2, r_lo_b2, r_da2, r_db2;

    t_out_item r_result;
    logic      r_done;

    logic              is_hash;
    logic              swap;
    logic [IDX_W-1:0]  s_a, e_a, s_b, e_b, k;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] t_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              bad_a, bad_b;
    logic [CHAR_W-1:0] weight;
    logic [H1_W-1:0]   mm_a1, mm_b1, mm_r1, n_pre1;
    logic [H2_W-1:0]   mm_a2, mm_b2, mm_r2, n_pre2;

    // compare puts the earlier-starting substring on side A
    assign is_hash = (r_item.command == CMD_HASH);
    assign swap    = (r_item.command == CMD_COMPARE) && (r_item.start_b < r_item.start_a);
    assign s_a     = swap ? r_item.start_b : r_item.start_a;
    assign e_a     = swap ? r_item.end_b   : r_item.end_a;
    assign s_b     = swap ? r_item.start_a : r_item.start_b;
    assign e_b     = swap ? r_item.end_a   : r_item.end_b;
    assign k       = s_b - s_a;
    assign t_addr  = is_hash ? ADDR_W'(s_a) : ADDR_W'(k);
    assign wr_addr = ADDR_W'(r_len);

    assign bad_a = (r_item.start_a > r_item.end_a) || (LEN_W'(r_item.end_a) >= r_len);
    assign bad_b = (r_item.start_b > r_item.end_b) || (LEN_W'(r_item.end_b) >= r_len);

    assign o_status.command = r_item.command;
    assign o_status.bad     = bad_a || ((r_item.command == CMD_COMPARE) && bad_b);
    assign o_status.full    = (r_len == LEN_W'(MAX_LENGTH));

    always_comb begin
        unique case (i_ctl.rd_sel)
            RD_HI_A: rd_addr = ADDR_W'(e_a);
            RD_LO_A: rd_addr = ADDR_W'(s_a - IDX_W'(1));
            RD_HI_B: rd_addr = ADDR_W'(e_b);
            RD_LO_B: rd_addr = ADDR_W'(s_b - IDX_W'(1));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
    end

    // prefix memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_prefix) begin
            r_mem_pre1[wr_addr] <= n_pre1;
            r_mem_pre2[wr_addr] <= n_pre2;
        end
        r_pre1_rd <= r_mem_pre1[rd_addr];
        r_pre2_rd <= r_mem_pre2[rd_addr];
    end

    // power and inverse power tables
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_tables) begin
            r_mem_pow1[wr_addr] <= r_pow1;
            r_mem_pow2[wr_addr] <= r_pow2;
            r_mem_inv1[wr_addr] <= r_inv1;
            r_mem_inv2[wr_addr] <= r_inv2;
        end
        r_pow1_rd <= r_mem_pow1[t_addr];
        r_pow2_rd <= r_mem_pow2[t_addr];
        r_inv1_rd <= r_mem_inv1[t_addr];
        r_inv2_rd <= r_mem_inv2[t_addr];
    end

    // prefix captures; a range starting at zero has no lower prefix
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_en) begin
            unique case (i_ctl.cap_sel)
                RD_HI_A: begin
                    r_hi_a1 <= r_pre1_rd;
                    r_hi_a2 <= r_pre2_rd;
                end
                RD_LO_A: begin
                    r_lo_a1 <= (s_a == '0) ? '0 : r_pre1_rd;
                    r_lo_a2 <= (s_a == '0) ? '0 : r_pre2_rd;
                end
                RD_HI_B: begin
                    r_hi_b1 <= r_pre1_rd;
                    r_hi_b2 <= r_pre2_rd;
                end
                RD_LO_B: begin
                    r_lo_b1 <= (s_b == '0) ? '0 : r_pre1_rd;
                    r_lo_b2 <= (s_b == '0) ? '0 : r_pre2_rd;
                end
            endcase
        end
        if (i_ctl.diff) begin
            r_da1 <= sub_first(r_hi_a1, r_lo_a1);
            r_da2 <= sub_second(r_hi_a2, r_lo_a2);
            r_db1 <= sub_first(r_hi_b1, r_lo_b1);
            r_db2 <= sub_second(r_hi_b2, r_lo_b2);
        end
    end

    assign weight = CHAR_W'(r_item.character - LETTER_OFFSET);

    always_comb begin
        unique case (i_ctl.mul_op)
            OP_WEIGHT: begin
                mm_a1 = H1_W'(weight);
                mm_b1 = r_pow1;
                mm_a2 = H2_W'(weight);
                mm_b2 = r_pow2;
            end
            OP_BASE: begin
                mm_a1 = r_pow1;
                mm_b1 = H1_W'(HASH_BASE);
                mm_a2 = r_pow2;
                mm_b2 = H2_W'(HASH_BASE);
            end
            OP_INV: begin
                mm_a1 = r_inv1;
                mm_b1 = INV_FIRST;
                mm_a2 = r_inv2;
                mm_b2 = INV_SECOND;
            end
            OP_DIFF: begin
                mm_a1 = r_da1;
                mm_b1 = is_hash ? r_inv1_rd : r_pow1_rd;
                mm_a2 = r_da2;
                mm_b2 = is_hash ? r_inv2_rd : r_pow2_rd;
            end
        endcase
    end

    sphash_modmul u_modmul (
        .i_clk (i_clk),
        .i_a1  (mm_a1),
        .i_b1  (mm_b1),
        .i_a2  (mm_a2),
        .i_b2  (mm_b2),
        .o_r1  (mm_r1),
        .o_r2  (mm_r2)
    );

    assign n_pre1 = add_first(mm_r1, r_last1);
    assign n_pre2 = add_second(mm_r2, r_last2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_len   <= '0;
            r_pow1  <= H1_W'(1);
            r_pow2  <= H2_W'(1);
            r_inv1  <= H1_W'(1);
            r_inv2  <= H2_W'(1);
            r_last1 <= '0;
            r_last2 <= '0;
        end else begin
            if (i_ctl.wr_prefix) begin
                r_last1 <= n_pre1;
                r_last2 <= n_pre2;
            end
            if (i_ctl.upd_pow) begin
                r_pow1 <= mm_r1;
                r_pow2 <= mm_r2;
            end
            if (i_ctl.upd_inv) begin
                r_inv1 <= mm_r1;
                r_inv2 <= mm_r2;
                r_len  <= r_len + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.out_result || i_ctl.out_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_error) begin
            r_result <= '{hash_first: '0, hash_second: '0, equal: 1'b0, error: 1'b1};
        end else if (i_ctl.out_result) begin
            if (is_hash) begin
                r_result <= '{hash_first: mm_r1, hash_second: mm_r2,
                              equal: 1'b0, error: 1'b0};
            end else begin
                r_result <= '{hash_first: '0, hash_second: '0,
                              equal: (mm_r1 == r_db1) && (mm_r2 == r_db2), error: 1'b0};
            end
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

`default_nettype wire

/* src/substring_polynomial_hash_engine_top.sv */
// Top level: double-modulus base-31 substring hash engine.
// Clear and an ignored append are busy only in DECODE; append is busy through DECODE and APPEND;
// a bad query strobes after DECODE; hash or compare strobes after the READ, DIFF and MUL states.
// Query time is set by four reads of the prefix memory's one read port plus the 4-deep multiplier.
// One item in flight; busy drops in the strobe cycle, so the next item may start then.
// The receiver cannot stall: o_done marks each result beat for one cycle.
// Synchronous active-low reset empties the string; table memories are not cleared.
`default_nettype none

module substring_polynomial_hash_engine_top import sphash_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_done
);

    // controller <-> datapath
    t_ctl    ctl;
    t_status status;

    // Controller: IDLE -> DECODE, then clear/append/read-diff-multiply sequences.
    sphash_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    // Datapath: prefix hashes H(j), powers 31^j and 31^-j per modulus, one
    // shared two-lane modular multiplier and the result register.
    sphash_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_status (status),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

`default_nettype wire

/* src/sphash_checker.sv */
// Port-level checker for the hash engine, bound to the top level.
`default_nettype none

module sphash_checker import sphash_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_out_item o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not make the engine busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.error) |->
            (o_result.hash_first == '0 && o_result.hash_second == '0 && !o_result.equal))
        else $error("error result carries nonzero fields");

    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.equal) |->
            (o_result.hash_first == '0 && o_result.hash_second == '0))
        else $error("compare result carries hash values");

    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.hash_first < MOD_FIRST && o_result.hash_second < MOD_SECOND))
        else $error("hash not reduced below its modulus");

endmodule

bind substring_polynomial_hash_engine_top sphash_checker u_sphash_checker (.*);

`default_nettype wire
